// ===== hdl/mgds_pkg.sv =====
`default_nettype none
package mgds_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  // |sample| needs 17 bits, times a 16-bit gain
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int PROD_W    = MAG_W + GAIN_W;
  localparam int QUOT_W    = 16;
  localparam int STEP_W    = 4;

  localparam int MAX_CHANNELS_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIVISOR  = 3'd1;
  localparam int                   REG_GAIN_CH0      = 2;

  localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_out_t;

endpackage
`default_nettype wire

// ===== hdl/mgds_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle. Quotient is limited to
// 16 bits; ovf flags a quotient of 65536 or more.
module mgds_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mgds_pkg::PROD_W-1:0]  dividend,
  input  wire logic [mgds_pkg::GAIN_W-1:0]  divisor,
  output mgds_pkg::div_out_t                res
);

  logic                          busy_r;
  logic                          done_r;
  logic                          ovf_r;
  logic [mgds_pkg::STEP_W-1:0]   step_r;
  logic [mgds_pkg::GAIN_W-1:0]   rem_r;
  logic [mgds_pkg::QUOT_W-1:0]   dq_r;

  logic [mgds_pkg::GAIN_W:0]     trial;
  logic                          ge;
  logic [mgds_pkg::GAIN_W:0]     diff;
  logic [mgds_pkg::GAIN_W:0]     hi_part;

  assign hi_part = dividend[mgds_pkg::PROD_W-1:mgds_pkg::QUOT_W];
  assign trial   = {rem_r, dq_r[mgds_pkg::QUOT_W-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign diff    = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        // high half at or above divisor: quotient does not fit 16 bits
        ovf_r  <= hi_part >= {1'b0, divisor};
        rem_r  <= hi_part[mgds_pkg::GAIN_W-1:0];
        dq_r   <= dividend[mgds_pkg::QUOT_W-1:0];
      end else if (busy_r) begin
        rem_r  <= ge ? diff[mgds_pkg::GAIN_W-1:0] : trial[mgds_pkg::GAIN_W-1:0];
        dq_r   <= {dq_r[mgds_pkg::QUOT_W-2:0], ge};
        step_r <= step_r + 1'b1;
        if (&step_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = dq_r;

endmodule
`default_nettype wire

// ===== hdl/multichannel_gain_divide_saturate.sv =====
`default_nettype none
// Channel   Direction  Handshake                Payload
// in_       in         in_tvalid / in_tready    in_tdata  = sample_in
// out_      out        out_tvalid / out_tready  out_tdata = sample_out, out_tlast = frame_end
// cfg_      in         cfg_wr_en                cfg_index, cfg_wdata
//
// From accept to the next accept an item goes through: accept, a multiply
// step, divider load, 16 restoring steps at one quotient bit per cycle,
// result capture, then the load into the output register once it is free.
// Divisor zero skips multiply and divider: accept, then the output load.
// Synchronous active-low reset clears config to channel_count=1, rest 0.
// in_tready is high only while idle; a result held in the output register
// does not block the next item until that item's own result is ready.
module multichannel_gain_divide_saturate #(
  parameter int MAX_CHANNELS = mgds_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output      logic                                  in_tready,
  input  wire logic signed [mgds_pkg::SAMPLE_W-1:0]  in_tdata,   // [15:0] sample_in
  output      logic                                  out_tvalid,
  input  wire logic                                  out_tready,
  output      logic signed [mgds_pkg::SAMPLE_W-1:0]  out_tdata,  // [15:0] sample_out
  output      logic                                  out_tlast,  // frame_end
  input  wire logic                                  cfg_wr_en,
  input  wire logic [mgds_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mgds_pkg::CFG_W-1:0]            cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t                           state_r;
  logic [mgds_pkg::CNT_W-1:0]       ch_cnt_r;
  logic [mgds_pkg::GAIN_W-1:0]      divisor_r;
  logic [mgds_pkg::GAIN_W-1:0]      gain_r [MAX_CHANNELS];
  logic [1:0]                       chan_idx_r;

  logic [mgds_pkg::SAMPLE_W-1:0]    sample_r;
  logic [mgds_pkg::GAIN_W-1:0]      gsel_r;
  logic                             end_r;
  logic [mgds_pkg::PROD_W-1:0]      prod_r;
  logic                             start_r;
  logic [mgds_pkg::SAMPLE_W-1:0]    res_r;
  logic                             out_valid_r;
  logic [mgds_pkg::SAMPLE_W-1:0]    out_data_r;
  logic                             out_last_r;

  logic [mgds_pkg::CNT_W-1:0]       cnt_eff;
  logic [mgds_pkg::CNT_W-1:0]       last_idx;
  logic                             is_end;
  logic [mgds_pkg::GAIN_W-1:0]      gain_sel;
  logic [mgds_pkg::MAG_W-1:0]       mag;
  logic [mgds_pkg::PROD_W-1:0]      prod_nxt;
  logic [mgds_pkg::SAMPLE_W-1:0]    sat_res;
  logic                             accept;
  logic                             out_free;
  mgds_pkg::div_out_t               div_res;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r  <= 3'd1;
      divisor_r <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        gain_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mgds_pkg::REG_CHANNEL_COUNT: ch_cnt_r  <= cfg_wdata[mgds_pkg::CNT_W-1:0];
        mgds_pkg::REG_GAIN_DIVISOR:  divisor_r <= cfg_wdata[mgds_pkg::GAIN_W-1:0];
        default: begin
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (cfg_index == mgds_pkg::CFG_IDX_W'(mgds_pkg::REG_GAIN_CH0 + i)) begin
              gain_r[i] <= cfg_wdata[mgds_pkg::GAIN_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    if (ch_cnt_r == '0) begin
      cnt_eff = mgds_pkg::CNT_W'(1);
    end else if (ch_cnt_r > mgds_pkg::CNT_W'(MAX_CHANNELS)) begin
      cnt_eff = mgds_pkg::CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = ch_cnt_r;
    end
  end

  assign last_idx = cnt_eff - 1'b1;
  // a stale index at or past the last channel also ends the frame
  assign is_end   = {1'b0, chan_idx_r} >= last_idx;

  always_comb begin
    gain_sel = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (chan_idx_r == 2'(i)) begin
        gain_sel = gain_r[i];
      end
    end
  end

  assign mag = sample_r[mgds_pkg::SAMPLE_W-1]
             ? ({mgds_pkg::MAG_W{1'b0}} - {1'b1, sample_r})
             : {1'b0, sample_r};
  assign prod_nxt = {{(mgds_pkg::PROD_W-mgds_pkg::MAG_W){1'b0}}, mag}
                  * {{(mgds_pkg::PROD_W-mgds_pkg::GAIN_W){1'b0}}, gsel_r};

  always_comb begin
    if (!sample_r[mgds_pkg::SAMPLE_W-1]) begin
      if (div_res.ovf || div_res.quot >= mgds_pkg::SAT_MAX) begin
        sat_res = mgds_pkg::SAT_MAX;
      end else begin
        sat_res = div_res.quot;
      end
    end else begin
      if (div_res.ovf || div_res.quot >= mgds_pkg::SAT_MIN) begin
        sat_res = mgds_pkg::SAT_MIN;
      end else begin
        sat_res = '0 - div_res.quot;
      end
    end
  end

  mgds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (prod_r),
    .divisor  (divisor_r),
    .res      (div_res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chan_idx_r  <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            sample_r   <= in_tdata;
            gsel_r     <= gain_sel;
            end_r      <= is_end;
            chan_idx_r <= is_end ? 2'd0 : chan_idx_r + 2'd1;
            if (divisor_r == '0) begin
              res_r   <= in_tdata;
              state_r <= S_OUT;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= prod_nxt;
          start_r <= 1'b1;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_res.done) begin
            res_r   <= sat_res;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r  <= res_r;
            out_last_r  <= end_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
module tb;

  localparam int SAMPLE_W  = mgds_pkg::SAMPLE_W;
  localparam int GAIN_W    = mgds_pkg::GAIN_W;
  localparam int CNT_W     = mgds_pkg::CNT_W;
  localparam int CFG_IDX_W = mgds_pkg::CFG_IDX_W;
  localparam int CFG_W     = mgds_pkg::CFG_W;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = mgds_pkg::REG_CHANNEL_COUNT;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DIVISOR  = mgds_pkg::REG_GAIN_DIVISOR;
  localparam int                   REG_GAIN_CH0      = mgds_pkg::REG_GAIN_CH0;
  localparam logic [SAMPLE_W-1:0]  SAT_MAX = mgds_pkg::SAT_MAX;
  localparam logic [SAMPLE_W-1:0]  SAT_MIN = mgds_pkg::SAT_MIN;

  localparam int MAX_CH    = mgds_pkg::MAX_CHANNELS_DEF;
  localparam int IDLE_GAP  = 24;       // about one item through the divider
  localparam int MAX_CYCLES = 500000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
  } gained_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic signed [SAMPLE_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // predictor copy of the block's registers and channel counter
  logic [CNT_W-1:0]  ch_count = 3'd1;
  logic [GAIN_W-1:0] divisor = '0;
  logic [GAIN_W-1:0] gains [4] = '{default: '0};
  logic [1:0]        chan_idx = 2'd0;

  gained_sample_t expected_samples [$];
  int errors = 0;
  int snd_idle_pct = 6;
  int rcv_idle_pct = 65;
  longint cycle_count = 0;

  multichannel_gain_divide_saturate i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    gained_sample_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected item: sample %0d last %0b", out_tdata, out_tlast);
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want.sample || out_tlast !== want.frame_end) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                     want.sample, want.frame_end, out_tdata, out_tlast);
        end
      end
    end
  end

  // Gain, truncating divide, saturate (or pass-through on divisor zero); advances the channel counter.
  function automatic gained_sample_t predict_gained(input logic signed [SAMPLE_W-1:0] s);
    gained_sample_t r;
    logic signed [32:0] prod;
    logic signed [32:0] quo;
    logic [CNT_W-1:0] eff;
    logic [1:0] idx;
    idx = chan_idx;
    if (ch_count == 0)
      eff = 3'd1;
    else if (ch_count > MAX_CH)
      eff = CNT_W'(MAX_CH);
    else
      eff = ch_count;
    if (divisor == 0) begin
      r.sample = s;
    end else begin
      prod = s;
      prod = prod * $signed({17'b0, gains[idx]});
      quo = prod / $signed({17'b0, divisor});
      if (quo >= 32767)
        r.sample = SAT_MAX;
      else if (quo <= -32768)
        r.sample = SAT_MIN;
      else
        r.sample = quo[SAMPLE_W-1:0];
    end
    // a stale counter at or past the last channel still ends the frame
    r.frame_end = ({1'b0, idx} >= eff - 3'd1);
    chan_idx = r.frame_end ? 2'd0 : idx + 2'd1;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_CHANNEL_COUNT)
      ch_count = data[CNT_W-1:0];
    else if (idx == REG_GAIN_DIVISOR)
      divisor = data;
    else if (idx >= REG_GAIN_CH0 && idx <= REG_GAIN_CH0 + 3)
      gains[idx - REG_GAIN_CH0] = data;
    @(posedge clk);
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] g0, g1, g2, g3);
    write_reg(CFG_IDX_W'(REG_GAIN_CH0),     g0);
    write_reg(CFG_IDX_W'(REG_GAIN_CH0 + 1), g1);
    write_reg(CFG_IDX_W'(REG_GAIN_CH0 + 2), g2);
    write_reg(CFG_IDX_W'(REG_GAIN_CH0 + 3), g3);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    expected_samples.push_back(predict_gained(s));
  endtask

  // Sender holds off until every result is back, then lets the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(11))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_bypass();
    // reset state: one channel, divisor zero, samples pass untouched
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh0001);
  endtask

  task automatic test_saturation();
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 16'd2);
    write_reg(REG_GAIN_DIVISOR, 16'd1);
    write_gains(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    wait_idle();
    // gain equal to divisor lands exactly on both rails
    write_reg(REG_GAIN_DIVISOR, 16'hFFFF);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    wait_idle();
    // zero gain, and a quotient truncated toward zero
    write_gains(16'd0, 16'd1, 16'd0, 16'd0);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
  endtask

  task automatic test_channel_count_limits();
    wait_idle();
    write_reg(REG_GAIN_DIVISOR, 16'd3);
    write_gains(16'd1, 16'd2, 16'd3, 16'hFFFF);
    write_reg(REG_CHANNEL_COUNT, 16'd0);
    send_sample(-16'sd7);
    send_sample(16'sd7);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 16'd7);
    send_sample(-16'sd7);
    send_sample(16'sd7);
    send_sample(16'sh8000);
    send_sample(16'sd5);
  endtask

  task automatic test_stale_index();
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 16'd4);
    send_sample(16'sd1);
    send_sample(16'sd2);
    send_sample(16'sd3);
    wait_idle();
    // counter sits on channel 3, beyond the new frame length
    write_reg(REG_CHANNEL_COUNT, 16'd2);
    send_sample(16'sd100);
    send_sample(16'sd100);
  endtask

  task automatic test_unknown_index();
    wait_idle();
    write_reg(REG_UNUSED_LO, 16'hFFFF);
    write_reg(REG_UNUSED_HI, 16'h0001);
    send_sample(16'sh4000);
    send_sample(-16'sd300);
  endtask

  task automatic test_random(input int snd_pct, input int rcv_pct, input int n_items);
    int sent;
    int seg_len;
    sent = 0;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    while (sent < n_items) begin
      wait_idle();
      write_reg(REG_CHANNEL_COUNT, 16'($urandom_range(7)));
      write_reg(REG_GAIN_DIVISOR, pick_word());
      write_gains(pick_word(), pick_word(), pick_word(), pick_word());
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, 16'($urandom));
      seg_len = $urandom_range(5, 40);
      if (seg_len > n_items - sent)
        seg_len = n_items - sent;
      repeat (seg_len) send_sample(pick_sample());
      sent += seg_len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_bypass();
    test_saturation();
    test_channel_count_limits();
    test_stale_index();
    test_unknown_index();
    test_random(6, 65, 150);
    test_random(65, 6, 150);
    test_random(0, 0, 150);
    wait_idle();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
